// ===== rtl/pba_pkg.sv =====
// Package for the page bitmap allocator: request/response types, opcodes,
// controller states and default sizes. No dependencies.
package pba_pkg;

  localparam int NUM_BLOCKS_DEF = 32768;
  localparam int WORD_BITS_DEF  = 32;

  localparam int IDX_W = 15;
  localparam int CNT_W = 16;

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 16'd32768;
  localparam logic [CNT_W-1:0] FOUND_NONE        = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_MARK = 2'd0,
    OP_FREE = 2'd1,
    OP_TEST = 2'd2,
    OP_FIND = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_READ,
    ST_MODIFY,
    ST_FIND
  } state_t;

  typedef struct packed {
    op_t              opcode;
    logic [IDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] found_index;
    logic                    bit_state;
    logic [CNT_W-1:0]        used_count;
    logic                    index_error;
  } rsp_t;

endpackage

// ===== rtl/pba_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/page_bitmap_allocator.sv =====
// Page bitmap allocator top level. Uses pba_pkg and pba_ram.
// Mark/free/test: the result strobe follows accept through the split, read and
// modify states; an out-of-range index answers in the cycle after accept.
// Find: one bitmap word read per cycle.
// Results cannot be stalled. Synchronous reset: a fill pass writes all ones
// to the WORD_COUNT bitmap words (busy high); count = NUM_BLOCKS.
module page_bitmap_allocator
  import pba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output logic             done,
  output rsp_t             rsp
);

  localparam int WORD_COUNT = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BW         = $clog2(WORD_BITS);
  localparam int BASE_W     = CNT_W + 1;
  // word = (idx * RECIP) >> RECIP_SH, exact for every 15-bit index
  localparam int RECIP_SH   = IDX_W + BW;
  localparam int RECIP_W    = IDX_W + 2;
  localparam int RECIP_INT  = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W     = IDX_W + RECIP_W;

  localparam logic [RECIP_W-1:0]   RECIP      = RECIP_W'(RECIP_INT);
  localparam logic [AW-1:0]        LAST_WORD  = AW'(WORD_COUNT - 1);
  localparam logic [BASE_W-1:0]    STEP       = BASE_W'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ALL_USED   = '1;
  localparam logic [CNT_W-1:0]     USED_RESET = CNT_W'(NUM_BLOCKS);

  state_t state, state_next;

  logic [CNT_W-1:0]  block_count;
  logic [CNT_W-1:0]  used_total, used_total_next;
  logic [CNT_W-1:0]  cnt_eff;

  op_t               op_q, op_next;
  logic [IDX_W-1:0]  idx_q, idx_next;
  logic [CNT_W-1:0]  cnt_q, cnt_next;
  logic [AW-1:0]     word_q, word_next;
  logic [BW-1:0]     bit_q, bit_next;
  logic [AW-1:0]     clr_addr, clr_addr_next;

  logic [AW-1:0]     scan_addr, scan_addr_next;
  logic [BASE_W-1:0] scan_base, scan_base_next;
  logic              issue_on, issue_on_next;
  logic              chk_valid, chk_valid_next;
  logic              chk_last, chk_last_next;
  logic [BASE_W-1:0] chk_base, chk_base_next;
  logic              more_words;

  logic              done_next;
  rsp_t              rsp_next;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic [PROD_W-1:0] prod;
  logic              accept;
  logic              idx_err;
  logic              old_bit;
  logic              hit;
  logic [BW-1:0]     hit_pos;
  logic [BASE_W-1:0] limit;

  pba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign cnt_eff = ({16'b0, block_count} > 32'(NUM_BLOCKS)) ? USED_RESET : block_count;
  assign idx_err = ({1'b0, req.block_index} >= cnt_eff);
  assign prod    = PROD_W'(idx_q) * PROD_W'(RECIP);
  assign old_bit = mem_rdata[bit_q];
  assign more_words = ((scan_base + STEP) < {1'b0, cnt_q});

  // lowest free bit of the word under check, bits at or past the count masked
  always_comb begin
    limit   = {1'b0, cnt_q} - chk_base;
    hit     = 1'b0;
    hit_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!mem_rdata[b] && (BASE_W'(b) < limit)) begin
        hit     = 1'b1;
        hit_pos = BW'(b);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (req.opcode == OP_FIND) begin
            state_next = (cnt_eff == '0) ? ST_IDLE : ST_FIND;
          end else if (!idx_err) begin
            state_next = ST_SPLIT;
          end
        end
      end
      ST_SPLIT:  state_next = ST_READ;
      ST_READ:   state_next = ST_MODIFY;
      ST_MODIFY: state_next = ST_IDLE;
      ST_FIND: begin
        if (chk_valid && (hit || chk_last)) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_next         = op_q;
    idx_next        = idx_q;
    cnt_next        = cnt_q;
    word_next       = word_q;
    bit_next        = bit_q;
    clr_addr_next   = clr_addr;
    scan_addr_next  = scan_addr;
    scan_base_next  = scan_base;
    issue_on_next   = issue_on;
    chk_valid_next  = 1'b0;
    chk_last_next   = chk_last;
    chk_base_next   = chk_base;
    used_total_next = used_total;
    done_next       = 1'b0;
    rsp_next        = rsp;
    mem_we          = 1'b0;
    mem_waddr       = word_q;
    mem_wdata       = mem_rdata;
    mem_raddr       = word_q;

    case (state)
      ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = ALL_USED;
        clr_addr_next = AW'(clr_addr + 1'b1);
      end
      ST_IDLE: begin
        if (accept) begin
          op_next        = req.opcode;
          idx_next       = req.block_index;
          cnt_next       = cnt_eff;
          scan_addr_next = '0;
          scan_base_next = '0;
          issue_on_next  = 1'b1;
          if (req.opcode == OP_FIND) begin
            if (cnt_eff == '0) begin
              done_next = 1'b1;
              rsp_next  = '{found_index: FOUND_NONE, bit_state: 1'b0,
                            used_count: used_total, index_error: 1'b0};
            end
          end else if (idx_err) begin
            done_next = 1'b1;
            rsp_next  = '{found_index: '0, bit_state: 1'b0,
                          used_count: used_total, index_error: 1'b1};
          end
        end
      end
      ST_SPLIT: begin
        word_next = AW'(prod >> RECIP_SH);
      end
      ST_READ: begin
        mem_raddr = word_q;
        bit_next  = BW'(idx_q - IDX_W'(word_q * WORD_BITS));
      end
      ST_MODIFY: begin
        if (op_q == OP_MARK && !old_bit) begin
          mem_we          = 1'b1;
          mem_wdata       = mem_rdata | (WORD_BITS'(1) << bit_q);
          used_total_next = CNT_W'(used_total + 1'b1);
        end else if (op_q == OP_FREE && old_bit) begin
          mem_we          = 1'b1;
          mem_wdata       = mem_rdata & ~(WORD_BITS'(1) << bit_q);
          used_total_next = CNT_W'(used_total - 1'b1);
        end
        done_next = 1'b1;
        rsp_next  = '{found_index: '0, bit_state: old_bit,
                      used_count: used_total_next, index_error: 1'b0};
      end
      ST_FIND: begin
        // reads stream one word per cycle; each word is checked in the cycle after its read
        mem_raddr = scan_addr;
        if (issue_on) begin
          chk_valid_next = 1'b1;
          chk_base_next  = scan_base;
          chk_last_next  = !more_words;
          scan_base_next = scan_base + STEP;
          scan_addr_next = AW'(scan_addr + 1'b1);
          issue_on_next  = more_words;
        end
        if (chk_valid && (hit || chk_last)) begin
          issue_on_next  = 1'b0;
          chk_valid_next = 1'b0;
          done_next      = 1'b1;
          rsp_next       = '{found_index: hit ? CNT_W'(chk_base + BASE_W'(hit_pos))
                                              : FOUND_NONE,
                             bit_state: 1'b0, used_count: used_total,
                             index_error: 1'b0};
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      used_total  <= USED_RESET;
      block_count <= BLOCK_COUNT_RESET;
      done        <= 1'b0;
      issue_on    <= 1'b0;
      chk_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      used_total  <= used_total_next;
      done        <= done_next;
      issue_on    <= issue_on_next;
      chk_valid   <= chk_valid_next;
      if (cfg_we) begin
        block_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q      <= op_next;
    idx_q     <= idx_next;
    cnt_q     <= cnt_next;
    word_q    <= word_next;
    bit_q     <= bit_next;
    scan_addr <= scan_addr_next;
    scan_base <= scan_base_next;
    chk_last  <= chk_last_next;
    chk_base  <= chk_base_next;
    rsp       <= rsp_next;
  end

  // a result is only ever presented once the controller is back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while controller busy");

  // the used count only moves in the read-modify-write step
  a_count_rmw: assert property (@(posedge clk) disable iff (rst)
    (state != ST_MODIFY) |=> $stable(used_total))
    else $error("used count changed outside modify step");

  // a found block lies below the count latched with the request
  a_found_range: assert property (@(posedge clk) disable iff (rst)
    (done && op_q == OP_FIND && rsp.found_index != FOUND_NONE)
      |-> ($unsigned(rsp.found_index) < cnt_q))
    else $error("found index beyond block count");

  // a flagged index leaves the count alone and reports a clear bit
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.index_error) |-> (!rsp.bit_state && $stable(used_total)))
    else $error("flagged request disturbed state");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for page_bitmap_allocator: directed and random mark/free/test/find
// requests checked against a behavioral bitmap model. Depends on pba_pkg and page_bitmap_allocator.
module tb;
  import pba_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 1100;  // longest find scan plus margin

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic done;
  rsp_t rsp;

  page_bitmap_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .rsp       (rsp)
  );

  // behavioral copy of the allocator
  bit               used_map [NUM_BLOCKS_DEF];
  logic [CNT_W-1:0] used_total;
  logic [CNT_W-1:0] model_count;

  rsp_t expected_q [$];
  int   err_cnt;
  int   req_cnt;
  int   setting_cnt;
  int   found_cnt;
  int   flagged_cnt;
  int   cycle_cnt;
  bit   no_gaps;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic rsp_t predict_alloc(input op_t op, input logic [IDX_W-1:0] idx);
    rsp_t        r;
    int unsigned lim;
    int unsigned i;
    r = '0;
    lim = (model_count > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : model_count;
    if (op == OP_FIND) begin
      r.found_index = FOUND_NONE;
      for (i = 0; i < lim; i++) begin
        if (!used_map[i]) begin
          r.found_index = CNT_W'(i);
          found_cnt++;
          break;
        end
      end
    end else if (idx >= lim) begin
      r.index_error = 1'b1;
      flagged_cnt++;
    end else begin
      r.bit_state = used_map[idx];
      // count moves only when the bit really flips
      if (op == OP_MARK && !used_map[idx]) begin
        used_map[idx] = 1'b1;
        used_total = used_total + 1'b1;
      end else if (op == OP_FREE && used_map[idx]) begin
        used_map[idx] = 1'b0;
        used_total = used_total - 1'b1;
      end
    end
    r.used_count = used_total;
    return r;
  endfunction

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (rsp.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, rsp.found_index);
          err_cnt++;
        end
        if (rsp.bit_state !== want.bit_state) begin
          $error("bit_state: expected %0b, got %0b", want.bit_state, rsp.bit_state);
          err_cnt++;
        end
        if (rsp.used_count !== want.used_count) begin
          $error("used_count: expected %0d, got %0d", want.used_count, rsp.used_count);
          err_cnt++;
        end
        if (rsp.index_error !== want.index_error) begin
          $error("index_error: expected %0b, got %0b", want.index_error, rsp.index_error);
          err_cnt++;
        end
      end
    end
  end

  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drive one request, wait for it to be taken, record its expected result.
  task automatic send_req(input op_t op, input int unsigned idx);
    int unsigned gap;
    start <= 1'b1;
    req <= '{opcode: op, block_index: IDX_W'(idx)};
    do @(posedge clk); while (busy);
    expected_q.push_back(predict_alloc(op, IDX_W'(idx)));
    req_cnt++;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    while (expected_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_block_count(input logic [CNT_W-1:0] value);
    drain_requests();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_count = value;
    setting_cnt++;
  endtask

  // Fully used bitmap after reset, free/mark idempotence, top block.
  task automatic test_reset_defaults();
    send_req(OP_TEST, 0);
    send_req(OP_TEST, 32767);
    send_req(OP_FIND, 0);
    send_req(OP_FREE, 0);
    send_req(OP_FREE, 0);
    send_req(OP_FIND, 0);
    send_req(OP_MARK, 0);
    send_req(OP_MARK, 0);
    send_req(OP_FREE, 32767);
    send_req(OP_FIND, 0);
    send_req(OP_TEST, 15'h5555);
    send_req(OP_TEST, 15'h2AAA);
    send_req(OP_MARK, 32767);
  endtask

  // Zero count, single block, and a count above the bitmap size.
  task automatic test_count_limits();
    write_block_count(16'd0);
    send_req(OP_TEST, 0);
    send_req(OP_FIND, 0);
    send_req(OP_MARK, 5);
    write_block_count(16'd1);
    send_req(OP_FREE, 1);
    send_req(OP_FREE, 0);
    send_req(OP_FIND, 0);
    send_req(OP_MARK, 0);
    write_block_count(16'hFFFF);
    send_req(OP_TEST, 32767);
    send_req(OP_FREE, 32767);
    send_req(OP_FIND, 0);
    send_req(OP_MARK, 32767);
  endtask

  task automatic run_random_phase(input logic [CNT_W-1:0] cnt, input int n_items);
    int unsigned eff;
    int unsigned win;
    int unsigned r;
    int unsigned idx;
    op_t         op;
    write_block_count(cnt);
    eff = (cnt > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : cnt;
    win = (eff < 64) ? eff : 64;
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 25) op = OP_MARK;
      else if (r < 55) op = OP_FREE;
      else if (r < 75) op = OP_TEST;
      else op = OP_FIND;
      r = $urandom_range(0, 99);
      if (eff == 0 || r >= 90) idx = $urandom_range(0, 32767);
      else if (r < 70) idx = $urandom_range(0, win - 1);
      else idx = $urandom_range(0, eff - 1);
      send_req(op, idx);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(16'd40, 100);
    run_random_phase(16'd1, 40);
    run_random_phase(16'd300, 100);
    run_random_phase(16'd32768, 100);
    run_random_phase(16'hFFFF, 80);
    run_random_phase(CNT_W'($urandom_range(1, 32768)), 120);
    run_random_phase(16'd0, 20);
  endtask

  initial begin
    foreach (used_map[i]) used_map[i] = 1'b1;
    used_total = CNT_W'(NUM_BLOCKS_DEF);
    model_count = BLOCK_COUNT_RESET;
    err_cnt = 0;
    req_cnt = 0;
    setting_cnt = 0;
    found_cnt = 0;
    flagged_cnt = 0;
    cycle_cnt = 0;
    no_gaps = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_count_limits();
    test_random_traffic();

    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests over %0d block_count writes (0, 1, 40, 300, 32768, 65535, random).",
             req_cnt, setting_cnt);
    $display("%0d finds located a free block; %0d indices flagged out of range.",
             found_cnt, flagged_cnt);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
